/* design/pdsum_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdsum_pkg: shared types and constants for the proper divisor sum block
// Widths of the number, trial divisor and sum, the sequencer states and the
// divider result bundle.
// ----------------------------------------------------------------------------
package pdsum_pkg;

	// Width of the number field on the input port
	localparam int DATA_W      = 32;
	// Number of low bits of the input that are examined
	localparam int NUMBER_BITS = 32;
	// Trial divisors never pass sqrt(2^DATA_W), so half the width plus one
	localparam int DIV_W       = DATA_W / 2 + 1;
	// Width of the divisor sum field
	localparam int SUM_W       = 35;
	// Step counter of the divider, wide enough to hold DATA_W
	localparam int CNT_W       = $clog2(DATA_W + 1);

	// Mask that keeps the examined bits of the number
	localparam logic [DATA_W-1:0] NUM_MASK = (NUMBER_BITS >= DATA_W) ?
		{DATA_W{1'b1}} : DATA_W'((64'd1 << NUMBER_BITS) - 64'd1);

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_DIV,
		ST_ADD_D,
		ST_ADD_Q,
		ST_DONE
	} pdsum_state_t;

	// Status from the divider to the sequencer
	typedef struct packed {
		logic              done;
		logic              rem_zero;
		logic [DATA_W-1:0] quotient;
	} pdsum_div_res_t;

endpackage

/* design/proper_divisor_sum_perfect_check_top.sv */
`timescale 1ns / 1ps
// Sequence: for inputs 0 and 1 the result is offered the cycle after the input is taken;
// otherwise each trial divisor passes through a start state, the iterative divider
// including its done pulse, and up to two add states, over roughly sqrt(number) trial divisors.
// Throughput: one transaction at a time; the shared iterative divider sets the pace.
// Reset: arst_n clears the sequencer and output valid; no result is pending.
// ----------------------------------------------------------------------------
// proper_divisor_sum_perfect_check_top: aliquot sum by trial division
// Sums the proper divisors of the input number and flags perfect numbers,
// using one shared iterative divider under a small sequencer.
// ----------------------------------------------------------------------------
module proper_divisor_sum_perfect_check_top
	import pdsum_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [DATA_W-1:0] number,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [SUM_W-1:0]  divisor_sum,
	output logic              is_perfect
);

	pdsum_state_t      state_q, state_d;

	logic [DATA_W-1:0] n_q;
	logic [DIV_W-1:0]  d_q;
	logic [SUM_W-1:0]  sum_q;
	logic              perfect_q;

	logic [DATA_W-1:0] n_in;
	logic              div_start;
	logic              load;
	logic              inc_d;
	logic              add_en;
	logic              add_sel;
	logic              finish;
	logic              d_gt_q;
	logic [SUM_W-1:0]  addend;
	pdsum_div_res_t    div_res;

	assign n_in   = number & NUM_MASK;
	assign d_gt_q = ({{(DATA_W-DIV_W){1'b0}}, d_q} > div_res.quotient);

	pdsum_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (n_q),
		.divisor  (d_q),
		.res      (div_res)
	);

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath controls
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		load      = 1'b0;
		inc_d     = 1'b0;
		add_en    = 1'b0;
		add_sel   = 1'b0;
		finish    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					load    = 1'b1;
					state_d = (n_in < DATA_W'(2)) ? ST_DONE : ST_START;
				end
			end
			ST_START: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_res.done) begin
					if (d_gt_q) begin
						finish  = 1'b1;
						state_d = ST_DONE;
					end else if (div_res.rem_zero) begin
						state_d = ST_ADD_D;
					end else begin
						inc_d   = 1'b1;
						state_d = ST_START;
					end
				end
			end
			ST_ADD_D: begin
				add_en = 1'b1;
				if (div_res.quotient != {{(DATA_W-DIV_W){1'b0}}, d_q}) begin
					state_d = ST_ADD_Q;
				end else begin
					inc_d   = 1'b1;
					state_d = ST_START;
				end
			end
			ST_ADD_Q: begin
				add_en  = 1'b1;
				add_sel = 1'b1;
				inc_d   = 1'b1;
				state_d = ST_START;
			end
			ST_DONE: begin
				if (!out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Shared adder operand: divisor or its cofactor; the sum of a 32-bit
	// number's proper divisors stays below 2^35, so no saturation is needed
	assign addend = add_sel ? SUM_W'(div_res.quotient) : SUM_W'(d_q);

	// Advance the number, trial divisor, running sum and perfect flag
	always_ff @(posedge clk) begin
		if (load) begin
			n_q       <= n_in;
			d_q       <= DIV_W'(2);
			sum_q     <= (n_in < DATA_W'(2)) ? SUM_W'(0) : SUM_W'(1);
			perfect_q <= 1'b0;
		end else begin
			if (inc_d) begin
				d_q <= d_q + DIV_W'(1);
			end
			if (add_en) begin
				sum_q <= sum_q + addend;
			end
			if (finish) begin
				perfect_q <= (n_q != '0) && (SUM_W'(n_q) == sum_q);
			end
		end
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = (state_q == ST_DONE);
	assign divisor_sum = sum_q;
	assign is_perfect  = perfect_q;

endmodule

/* design/pdsum_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdsum_div: iterative restoring divider
// Produces one quotient bit per cycle; the quotient and remainder-zero flag
// hold after the done pulse until the next start.
// ----------------------------------------------------------------------------
module pdsum_div
	import pdsum_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] dividend,
	input  logic [DIV_W-1:0]  divisor,
	output pdsum_div_res_t    res
);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DATA_W-1:0] quo_q;

	logic [DIV_W:0]    trial;
	logic              fits;
	logic [DIV_W:0]    diff;

	// Shift in the next dividend bit and trial-subtract the divisor
	always_comb begin
		trial = {rem_q, quo_q[DATA_W-1]};
		fits  = (trial >= {1'b0, divisor});
		diff  = trial - {1'b0, divisor};
	end

	// Control: busy flag, step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DATA_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			quo_q <= {quo_q[DATA_W-2:0], fits};
		end
	end

	assign res.done     = done_q;
	assign res.rem_zero = (rem_q == '0);
	assign res.quotient = quo_q;

endmodule
